// ----- src/sem_pkg.sv -----
// Shared types, constants and helper functions for the Sobel energy map unit.
package sem_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int CFG_W       = 11;
   localparam int GREY_W      = 8;
   localparam int ENERGY_W    = 11;
   localparam int GRAD_W      = 12;
   localparam int MAG_W       = 10;
   localparam int SUM_W       = 21;
   localparam int ROOT_W      = 22;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int CFG_RESET   = 640;
   // floor(s/3) == (s*683)>>11 for s <= 765
   localparam int DIV3_MUL    = 683;
   localparam int DIV3_SHIFT  = 11;

   localparam logic REQ_PIXEL = 1'b0;
   localparam logic REQ_DRAIN = 1'b1;

   // command from the front end to the compute back end
   typedef struct packed {
      logic              is_drain;
      logic [GREY_W-1:0] grey;
      logic [COL_W-1:0]  col;
      logic              emit_left;
      logic              emit_here;
      logic              up_ok;
      logic              rotate;
      logic              frame_last;
   } cmd_type;

   // width register clamped into 1..MAX_WIDTH
   function automatic logic [CFG_W-1:0] eff_width(input logic [CFG_W-1:0] w);
      logic [CFG_W-1:0] r;
      r = w;
      if (w == '0) r = CFG_W'(1);
      else if (w > CFG_W'(MAX_WIDTH)) r = CFG_W'(MAX_WIDTH);
      return r;
   endfunction

   function automatic logic [GREY_W-1:0] grey_of(input logic [7:0] r,
                                                 input logic [7:0] g,
                                                 input logic [7:0] b);
      logic [9:0]  s;
      logic [19:0] p;
      s = 10'(r) + 10'(g) + 10'(b);
      p = s * 10'(DIV3_MUL);
      return p[DIV3_SHIFT +: GREY_W];
   endfunction

   // next line-store role index, modulo three
   function automatic logic [1:0] next3(input logic [1:0] i);
      return (i == 2'd2) ? 2'd0 : i + 2'd1;
   endfunction

endpackage

// ----- src/sem_queue.sv -----
// Small command FIFO between the front end and the compute back end.
module sem_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  sem_pkg::cmd_type  push_cmd,
   output logic              full,
   input  logic              pop,
   output sem_pkg::cmd_type  pop_cmd,
   output logic              empty
);

   sem_pkg::cmd_type slot_ff [sem_pkg::QUEUE_DEPTH];
   logic [sem_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [sem_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [sem_pkg::QPTR_W:0]   count_ff, count_in;

   assign full    = (count_ff == (sem_pkg::QPTR_W+1)'(sem_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_cmd = slot_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_cmd;
   end

endmodule

// ----- src/sem_front.sv -----
// Front end: accepts beats, makes grey, tracks row and drain position, queues commands.
module sem_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [23:0]                req_tdata,
   input  logic                       req_tuser,
   input  logic [sem_pkg::CFG_W-1:0]  eff_w,
   input  logic                       q_full,
   output logic                       q_push,
   output sem_pkg::cmd_type           q_cmd
);

   logic [sem_pkg::COL_W-1:0] col_cnt_ff, col_cnt_in;
   logic [1:0]                rows_ff, rows_in;
   logic [sem_pkg::COL_W-1:0] drain_col_ff, drain_col_in;

   logic                      accept;
   logic [sem_pkg::COL_W-1:0] x;
   logic [1:0]                rows_now;
   logic                      row_end;
   logic                      drain_end;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && !q_full;

   always_comb begin
      col_cnt_in   = col_cnt_ff;
      rows_in      = rows_ff;
      drain_col_in = drain_col_ff;
      q_push       = 1'b0;

      // a pixel after a partial drain starts a fresh frame
      x        = (drain_col_ff != '0) ? '0 : col_cnt_ff;
      rows_now = (drain_col_ff != '0) ? 2'd0 : rows_ff;
      row_end  = ((sem_pkg::CFG_W'(x) + 1'b1) >= eff_w);
      drain_end = ((sem_pkg::CFG_W'(drain_col_ff) + 1'b1) >= eff_w);

      q_cmd.is_drain   = req_tuser;
      q_cmd.grey       = sem_pkg::grey_of(req_tdata[7:0], req_tdata[15:8],
                                          req_tdata[23:16]);
      q_cmd.col        = x;
      q_cmd.emit_left  = (rows_now != 2'd0) && (x != '0);
      q_cmd.emit_here  = (rows_now != 2'd0) && row_end;
      q_cmd.up_ok      = (rows_now == 2'd2);
      q_cmd.rotate     = row_end;
      q_cmd.frame_last = 1'b0;

      if (req_tuser == sem_pkg::REQ_DRAIN) begin
         q_cmd.col        = drain_col_ff;
         q_cmd.emit_left  = 1'b0;
         q_cmd.emit_here  = 1'b1;
         q_cmd.up_ok      = (rows_ff == 2'd2);
         q_cmd.rotate     = 1'b0;
         q_cmd.frame_last = drain_end;
      end

      if (accept) begin
         if (req_tuser == sem_pkg::REQ_PIXEL) begin
            q_push       = 1'b1;
            drain_col_in = '0;
            col_cnt_in   = row_end ? '0 : x + 1'b1;
            rows_in      = (row_end && rows_now != 2'd2) ? rows_now + 2'd1 : rows_now;
         end else begin
            col_cnt_in = '0;
            if (rows_ff == 2'd0) begin
               // nothing buffered: just rearm
               drain_col_in = '0;
            end else begin
               q_push = 1'b1;
               if (drain_end) begin
                  rows_in      = 2'd0;
                  drain_col_in = '0;
               end else begin
                  drain_col_in = drain_col_ff + 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_cnt_ff   <= '0;
         rows_ff      <= '0;
         drain_col_ff <= '0;
      end else begin
         col_cnt_ff   <= col_cnt_in;
         rows_ff      <= rows_in;
         drain_col_ff <= drain_col_in;
      end
   end

endmodule

// ----- src/sem_back.sv -----
// Back end: line stores, 3x3 tap fetch, Sobel gradients, serial square root, result register.
module sem_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [sem_pkg::CFG_W-1:0]  eff_w,
   input  logic                       q_empty,
   input  sem_pkg::cmd_type           q_cmd,
   output logic                       q_pop,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [23:0]                rsp_tdata,
   output logic                       rsp_tuser,
   output logic                       rsp_tlast
);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_WRITE = 8'b0000_0010,
      ST_READ  = 8'b0000_0100,
      ST_GRAD  = 8'b0000_1000,
      ST_SQX   = 8'b0001_0000,
      ST_SQY   = 8'b0010_0000,
      ST_ROOT  = 8'b0100_0000,
      ST_EMIT  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   sem_pkg::cmd_type          cmd_ff, cmd_in;
   logic [sem_pkg::COL_W-1:0] res_col_ff, res_col_in;
   logic                      res_dn_ff, res_dn_in;
   logic                      res_last_ff, res_last_in;
   logic                      second_ff, second_in;
   logic [1:0]                rot_ff, rot_in;
   logic [1:0]                rd_k_ff, rd_k_in;

   logic [sem_pkg::GREY_W-1:0] line_mem [3][sem_pkg::MAX_WIDTH];
   logic [sem_pkg::GREY_W-1:0] rd_q_ff [3];
   logic [sem_pkg::GREY_W-1:0] up_tap_ff [3];
   logic [sem_pkg::GREY_W-1:0] mid_tap_ff [3];
   logic [sem_pkg::GREY_W-1:0] dn_tap_ff [3];

   logic [sem_pkg::MAG_W-1:0]  ax_ff, ay_ff, ax_in, ay_in;
   logic [sem_pkg::SUM_W-1:0]  rem_ff, rem_in;
   logic [sem_pkg::ROOT_W-1:0] root_ff, root_in;
   logic [sem_pkg::ROOT_W-1:0] bit_ff, bit_in;

   logic                        out_valid_ff, out_valid_in;
   logic [sem_pkg::ENERGY_W-1:0] out_energy_ff;
   logic [sem_pkg::COL_W-1:0]   out_col_ff;
   logic                        out_run_ff, out_frame_ff;
   logic                        out_load, out_free;

   logic [1:0] two_idx, one_idx, now_idx;
   logic       mem_we;
   logic [sem_pkg::COL_W-1:0] rd_addr;
   logic       hl, hr;
   logic [sem_pkg::GREY_W-1:0] ce, tl_l, tr_r, t_u, t_d, tl, tr, bl, br;
   logic signed [sem_pkg::GRAD_W-1:0] gx, gy;
   logic [sem_pkg::ROOT_W-1:0] trial;
   logic [2*sem_pkg::MAG_W-1:0] sq_in;

   // line-store roles rotate at each row end instead of copying rows
   assign two_idx = rot_ff;
   assign one_idx = sem_pkg::next3(rot_ff);
   assign now_idx = sem_pkg::next3(one_idx);

   // read address for the left, centre and right tap columns
   always_comb begin
      case (rd_k_ff)
         2'd0:    rd_addr = (res_col_ff == '0) ? '0 : res_col_ff - 1'b1;
         2'd2:    rd_addr = (res_col_ff == '1) ? res_col_ff : res_col_ff + 1'b1;
         default: rd_addr = res_col_ff;
      endcase
   end

   // line stores: one write and one registered read each
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (mem_we && now_idx == 2'(i)) line_mem[i][cmd_ff.col] <= cmd_ff.grey;
         rd_q_ff[i] <= line_mem[i][rd_addr];
      end
   end

   // border substitution and Sobel gradients
   always_comb begin
      hl   = (res_col_ff != '0);
      hr   = ((sem_pkg::CFG_W'(res_col_ff) + 1'b1) < eff_w);
      ce   = mid_tap_ff[1];
      tl_l = hl ? mid_tap_ff[0] : ce;
      tr_r = hr ? mid_tap_ff[2] : ce;
      t_u  = cmd_ff.up_ok ? up_tap_ff[1] : ce;
      t_d  = res_dn_ff ? dn_tap_ff[1] : ce;
      tl   = hl ? (cmd_ff.up_ok ? up_tap_ff[0] : tl_l) : ce;
      tr   = hr ? (cmd_ff.up_ok ? up_tap_ff[2] : tr_r) : ce;
      bl   = hl ? (res_dn_ff ? dn_tap_ff[0] : tl_l) : ce;
      br   = hr ? (res_dn_ff ? dn_tap_ff[2] : tr_r) : ce;
      gx = $signed(12'(tl)) - $signed(12'(tr))
         + ($signed(12'(tl_l)) - $signed(12'(tr_r))) * 12'sd2
         + $signed(12'(bl)) - $signed(12'(br));
      gy = $signed(12'(tl)) - $signed(12'(bl))
         + ($signed(12'(t_u)) - $signed(12'(t_d))) * 12'sd2
         + $signed(12'(tr)) - $signed(12'(br));
      ax_in = gx[sem_pkg::GRAD_W-1] ? sem_pkg::MAG_W'(-gx) : sem_pkg::MAG_W'(gx);
      ay_in = gy[sem_pkg::GRAD_W-1] ? sem_pkg::MAG_W'(-gy) : sem_pkg::MAG_W'(gy);
   end

   assign out_free = !out_valid_ff || rsp_tready;
   assign trial    = root_ff + bit_ff;
   assign sq_in    = (state_ff == ST_SQX) ? ax_ff * ax_ff : ay_ff * ay_ff;

   // sequencer
   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      res_col_in  = res_col_ff;
      res_dn_in   = res_dn_ff;
      res_last_in = res_last_ff;
      second_in   = second_ff;
      rot_in      = rot_ff;
      rd_k_in     = rd_k_ff;
      rem_in      = rem_ff;
      root_in     = root_ff;
      bit_in      = bit_ff;
      q_pop       = 1'b0;
      mem_we      = 1'b0;
      out_load    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            rd_k_in = '0;
            if (!q_empty) begin
               q_pop  = 1'b1;
               cmd_in = q_cmd;
               if (q_cmd.is_drain) begin
                  res_col_in  = q_cmd.col;
                  res_dn_in   = 1'b0;
                  res_last_in = 1'b1;
                  second_in   = 1'b0;
                  state_in    = ST_READ;
               end else begin
                  state_in = ST_WRITE;
               end
            end
         end
         ST_WRITE: begin
            mem_we    = 1'b1;
            res_dn_in = 1'b1;
            if (cmd_ff.emit_left) begin
               res_col_in  = cmd_ff.col - 1'b1;
               res_last_in = !cmd_ff.emit_here;
               second_in   = cmd_ff.emit_here;
               state_in    = ST_READ;
            end else if (cmd_ff.emit_here) begin
               res_col_in  = cmd_ff.col;
               res_last_in = 1'b1;
               second_in   = 1'b0;
               state_in    = ST_READ;
            end else begin
               if (cmd_ff.rotate) rot_in = sem_pkg::next3(rot_ff);
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            rd_k_in = rd_k_ff + 1'b1;
            if (rd_k_ff == 2'd3) state_in = ST_GRAD;
         end
         ST_GRAD: begin
            state_in = ST_SQX;
         end
         ST_SQX: begin
            rem_in   = sem_pkg::SUM_W'(sq_in);
            state_in = ST_SQY;
         end
         ST_SQY: begin
            rem_in   = rem_ff + sem_pkg::SUM_W'(sq_in);
            root_in  = '0;
            bit_in   = sem_pkg::ROOT_W'(1) << (sem_pkg::SUM_W - 1);
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            // one result bit per cycle
            if (sem_pkg::ROOT_W'(rem_ff) >= trial) begin
               rem_in  = rem_ff - sem_pkg::SUM_W'(trial);
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               out_load = 1'b1;
               rd_k_in  = '0;
               if (second_ff) begin
                  res_col_in  = cmd_ff.col;
                  res_last_in = 1'b1;
                  second_in   = 1'b0;
                  state_in    = ST_READ;
               end else begin
                  if (cmd_ff.rotate) rot_in = sem_pkg::next3(rot_ff);
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rot_ff   <= '0;
         rd_k_ff  <= '0;
      end else begin
         state_ff <= state_in;
         rot_ff   <= rot_in;
         rd_k_ff  <= rd_k_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      res_col_ff  <= res_col_in;
      res_dn_ff   <= res_dn_in;
      res_last_ff <= res_last_in;
      second_ff   <= second_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      bit_ff      <= bit_in;
      if (state_ff == ST_GRAD) begin
         ax_ff <= ax_in;
         ay_ff <= ay_in;
      end
      // tap data arrives in the cycle after its address
      if (state_ff == ST_READ && rd_k_ff != 2'd0) begin
         up_tap_ff[rd_k_ff - 2'd1]  <= rd_q_ff[two_idx];
         mid_tap_ff[rd_k_ff - 2'd1] <= rd_q_ff[one_idx];
         dn_tap_ff[rd_k_ff - 2'd1]  <= rd_q_ff[now_idx];
      end
   end

   // result register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_valid_ff && rsp_tready) out_valid_in = 1'b0;
      if (out_load) out_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else       out_valid_ff <= out_valid_in;
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_energy_ff <= root_ff[sem_pkg::ENERGY_W-1:0];
         out_col_ff    <= res_col_ff;
         out_run_ff    <= res_last_ff;
         out_frame_ff  <= cmd_ff.frame_last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_col_ff, out_energy_ff};
   assign rsp_tuser  = out_run_ff;
   assign rsp_tlast  = out_frame_ff;

endmodule

// ----- src/sobel_energy_map_unit.sv -----
// Top level of the Sobel energy map unit: width register, front end, queue, back end.
//
//   port group | dir | beat contents
//   req_*      | in  | tdata: red, green, blue; tuser: 0 pixel / 1 drain
//   rsp_*      | out | tdata: energy, column; tuser: run_last; tlast: frame_last
//   csr_*      | in  | image_width write
//
// Each result passes through the back-end states in order: ST_READ for the three
// tap columns (registered store read, data in the cycle after its address),
// ST_GRAD for the gradients, ST_SQX and ST_SQY for squaring, ST_ROOT for the
// bit-serial square root and ST_EMIT for the hand-off. Each command first leaves
// the queue in ST_IDLE, and a pixel also writes its line store in ST_WRITE; a
// stalled rsp_tready holds the hand-off. The four-entry queue lets the front end
// keep taking beats. Reset is synchronous; the line stores are not cleared.
module sobel_energy_map_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [23:0]                req_tdata,   // red[7:0], green[15:8], blue[23:16]
   input  logic                       req_tuser,   // req_type
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [23:0]                rsp_tdata,   // energy[10:0], column[20:11], zero
   output logic                       rsp_tuser,   // run_last
   output logic                       rsp_tlast,   // frame_last
   input  logic                       csr_wr_en,
   input  logic [sem_pkg::CFG_W-1:0]  csr_wr_data
);

   logic [sem_pkg::CFG_W-1:0] width_ff, width_in;
   logic [sem_pkg::CFG_W-1:0] eff_w;
   logic                      q_push, q_full, q_pop, q_empty;
   sem_pkg::cmd_type          push_cmd, pop_cmd;

   // width register
   assign width_in = csr_wr_en ? csr_wr_data : width_ff;
   assign eff_w    = sem_pkg::eff_width(width_ff);

   always_ff @(posedge clock) begin
      if (reset) width_ff <= sem_pkg::CFG_W'(sem_pkg::CFG_RESET);
      else       width_ff <= width_in;
   end

   sem_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .eff_w      (eff_w),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (push_cmd)
   );

   sem_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .pop_cmd  (pop_cmd),
      .empty    (q_empty)
   );

   sem_back u_back (
      .clock      (clock),
      .reset      (reset),
      .eff_w      (eff_w),
      .q_empty    (q_empty),
      .q_cmd      (pop_cmd),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef SYNTHESIS
   // end of frame is always the end of its run
   a_frame_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser) else $error("frame_last without run_last");
   // front end never pushes into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full) else $error("queue overflow");
   // back end only pops a non-empty queue
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty) else $error("queue underflow");
`endif

endmodule

// ----- sim/tb_top.sv -----
// Testbench for the Sobel energy map unit: a line-store window model checked against each response beat.
`timescale 1ns / 1ps
module tb_top;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [23:0] req_tdata = '0;   // red[7:0], green[15:8], blue[23:16]
   logic req_tuser = 1'b0;        // req_type
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // energy[10:0], column[20:11], zero
   logic rsp_tuser;               // run_last
   logic rsp_tlast;               // frame_last
   logic csr_wr_en = 1'b0;
   logic [sem_pkg::CFG_W-1:0] csr_wr_data = '0;

   sobel_energy_map_unit DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   typedef struct packed {
      logic [sem_pkg::ENERGY_W-1:0] energy;
      logic [sem_pkg::COL_W-1:0]    column;
      logic                         run_last;
      logic                         frame_last;
   } energy_beat_type;

   // model state
   logic [sem_pkg::CFG_W-1:0] width_reg = sem_pkg::CFG_W'(sem_pkg::CFG_RESET);
   logic [7:0] row_up [sem_pkg::MAX_WIDTH];
   logic [7:0] row_mid [sem_pkg::MAX_WIDTH];
   logic [7:0] row_cur [sem_pkg::MAX_WIDTH];
   int col_cnt, rows_done, drain_col;
   energy_beat_type energy_q[$];

   int mismatches = 0;
   int beats_checked = 0;
   int pixels_sent = 0;
   int drains_sent = 0;
   int idle_cycles = 0;
   bit no_idle = 1'b0;

   function automatic int width_eff();
      int w;
      w = width_reg;
      if (w == 0) w = 1;
      if (w > sem_pkg::MAX_WIDTH) w = sem_pkg::MAX_WIDTH;
      return w;
   endfunction

   function automatic int int_sqrt(int n);
      int r;
      r = 0;
      while ((r + 1) * (r + 1) <= n) r++;
      return r;
   endfunction

   // gradient magnitude at column c; has_up/has_dn select border substitution
   function automatic int sobel_mag(bit has_up, bit has_dn, int c, int w);
      bit hl, hr;
      int ce, l, r, u, d, tl, tr, bl, br, gx, gy;
      hl = c > 0;
      hr = (c + 1 < w) && (c + 1 < sem_pkg::MAX_WIDTH);
      ce = row_mid[c];
      l = hl ? row_mid[c-1] : ce;
      r = hr ? row_mid[c+1] : ce;
      u = has_up ? row_up[c] : ce;
      d = has_dn ? row_cur[c] : ce;
      tl = hl ? (has_up ? row_up[c-1] : l) : ce;
      tr = hr ? (has_up ? row_up[c+1] : r) : ce;
      bl = hl ? (has_dn ? row_cur[c-1] : l) : ce;
      br = hr ? (has_dn ? row_cur[c+1] : r) : ce;
      gx = tl - tr + 2 * (l - r) + bl - br;
      gy = tl - bl + 2 * (u - d) + tr - br;
      return int_sqrt(gx * gx + gy * gy);
   endfunction

   function automatic void push_energy(int e, int c, bit rl, bit fl);
      energy_beat_type b;
      b.energy = sem_pkg::ENERGY_W'(e);
      b.column = sem_pkg::COL_W'(c);
      b.run_last = rl;
      b.frame_last = fl;
      energy_q.push_back(b);
   endfunction

   function automatic void restart_frame();
      rows_done = 0;
      col_cnt = 0;
      drain_col = 0;
   endfunction

   // predict the beats caused by one accepted request
   function automatic void predict_energy(logic kind, logic [23:0] rgb);
      int w, x, n;
      w = width_eff();
      if (kind == sem_pkg::REQ_PIXEL) begin
         if (drain_col != 0) restart_frame();
         x = col_cnt;
         if (x >= sem_pkg::MAX_WIDTH) x = sem_pkg::MAX_WIDTH - 1;
         row_cur[x] = 8'((int'(rgb[7:0]) + int'(rgb[15:8]) + int'(rgb[23:16])) / 3);
         n = 0;
         if (rows_done >= 1) begin
            if (x >= 1) begin
               push_energy(sobel_mag(rows_done >= 2, 1'b1, x - 1, w), x - 1, 1'b0, 1'b0);
               n++;
            end
            if (x + 1 >= w) begin
               push_energy(sobel_mag(rows_done >= 2, 1'b1, x, w), x, 1'b0, 1'b0);
               n++;
            end
            if (n > 0) energy_q[$].run_last = 1'b1;
         end
         if (x + 1 >= w) begin
            row_up = row_mid;
            row_mid = row_cur;
            if (rows_done < 2) rows_done++;
            col_cnt = 0;
         end else begin
            col_cnt = x + 1;
         end
      end else begin
         col_cnt = 0;
         if (rows_done == 0) begin
            restart_frame();
         end else begin
            x = drain_col;
            if (x >= sem_pkg::MAX_WIDTH) x = sem_pkg::MAX_WIDTH - 1;
            push_energy(sobel_mag(rows_done >= 2, 1'b0, x, w), x, 1'b1, x + 1 >= w);
            if (x + 1 >= w) restart_frame();
            else drain_col = x + 1;
         end
      end
   endfunction

   // send one request beat, with random idle gaps; valid stays high until the next gap
   task automatic send_beat(logic kind, logic [23:0] rgb);
      int gaps;
      gaps = 0;
      while (!no_idle && $urandom_range(99) < 10) gaps++;
      if (gaps > 0) begin
         req_tvalid <= 1'b0;
         repeat (gaps) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= rgb;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_energy(kind, rgb);
      if (kind == sem_pkg::REQ_PIXEL) pixels_sent++;
      else drains_sent++;
   endtask

   task automatic send_pixel(logic [23:0] rgb);
      send_beat(sem_pkg::REQ_PIXEL, rgb);
   endtask

   task automatic send_drain();
      send_beat(sem_pkg::REQ_DRAIN, 24'($urandom));
   endtask

   // wait until the unit is idle, then write the width register
   task automatic set_width(int w);
      req_tvalid <= 1'b0;
      while (energy_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= sem_pkg::CFG_W'(w);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      width_reg = sem_pkg::CFG_W'(w);
   endtask

   function automatic logic [23:0] rand_rgb();
      return 24'($urandom);
   endfunction

   // send a well-formed frame and flush it
   task automatic send_frame(int rows);
      int w;
      w = width_eff();
      for (int y = 0; y < rows; y++)
         for (int x = 0; x < w; x++) send_pixel(rand_rgb());
      for (int x = 0; x < w; x++) send_drain();
   endtask

   // response sink: random stall, compare against oldest prediction
   always @(posedge clock) begin
      energy_beat_type got, want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.energy = rsp_tdata[10:0];
            got.column = rsp_tdata[20:11];
            got.run_last = rsp_tuser;
            got.frame_last = rsp_tlast;
            beats_checked++;
            if (energy_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected beat: energy %0d col %0d", got.energy, got.column);
            end else begin
               want = energy_q.pop_front();
               if (got !== want || rsp_tdata[23:21] !== 3'b000) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp e=%0d c=%0d rl=%0b fl=%0b got e=%0d c=%0d rl=%0b fl=%0b",
                              want.energy, want.column, want.run_last, want.frame_last,
                              got.energy, got.column, got.run_last, got.frame_last);
               end
            end
         end
         rsp_tready <= no_idle || ($urandom_range(99) >= 10);
      end
   end

   // watchdog on cycles without any accepted beat
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("sobel_energy_map_unit verification failed");
         $finish;
      end
   end

   task automatic test_corners();
      // extremes of the channels on a tiny image
      set_width(3);
      send_pixel(24'h000000); send_pixel(24'hFFFFFF); send_pixel(24'h000000);
      send_pixel(24'hFFFFFF); send_pixel(24'h000000); send_pixel(24'hFFFFFF);
      send_pixel(24'hFF00FF); send_pixel(24'h00FF00); send_pixel(24'hFFFFFF);
      send_drain(); send_drain(); send_drain();
   endtask

   task automatic test_odd_cases();
      // drain with no row done, drain after partial row, pixel mid-drain
      set_width(4);
      send_drain();
      send_pixel(24'h102030); send_pixel(24'hFFFFFF);
      send_drain();
      send_frame(1);
      for (int i = 0; i < 8; i++) send_pixel(rand_rgb());
      send_drain();
      send_pixel(24'h00FF00);
      send_drain();
   endtask

   task automatic test_widths();
      // register values: zero, one, two, over the maximum and the reset value (partial rows only for the last two)
      set_width(0);
      send_frame(3);
      set_width(1);
      send_frame(2);
      set_width(2);
      send_frame(3);
      set_width(2047);
      for (int i = 0; i < 12; i++) send_pixel(rand_rgb());
      send_drain();
      set_width(sem_pkg::CFG_RESET);
      for (int i = 0; i < 12; i++) send_pixel(rand_rgb());
      send_drain();
   endtask

   task automatic test_random();
      int w, sel;
      for (int f = 0; f < 30; f++) begin
         w = $urandom_range(1, 8);
         set_width(w);
         no_idle = (f >= 20 && f < 25);
         sel = $urandom_range(9);
         if (sel < 8) send_frame($urandom_range(1, 4));
         else begin
            for (int i = 0; i < $urandom_range(1, 20); i++)
               send_beat($urandom_range(3) == 0 ? sem_pkg::REQ_DRAIN : sem_pkg::REQ_PIXEL,
                         rand_rgb());
            for (int i = 0; i < w + 1; i++) send_drain();
         end
      end
      no_idle = 1'b0;
   endtask

   initial begin
      restart_frame();
      for (int i = 0; i < sem_pkg::MAX_WIDTH; i++) begin
         row_up[i] = 8'd0; row_mid[i] = 8'd0; row_cur[i] = 8'd0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_corners();
      test_odd_cases();
      test_widths();
      test_random();
      req_tvalid <= 1'b0;
      while (energy_q.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("covered %0d pixels and %0d drains over widths 1 to %0d",
               pixels_sent, drains_sent, sem_pkg::MAX_WIDTH);
      $display("%0d energy beats checked, %0d mismatches", beats_checked, mismatches);
      if (mismatches == 0 && energy_q.size() == 0)
         $display("sobel_energy_map_unit verification clean");
      else
         $display("sobel_energy_map_unit verification failed");
      $finish;
   end
endmodule
